@@ sv/lgks_pkg.sv @@
// lgks_pkg: shared constants for the key-lifetime watchdog and its key shredder.
// No dependencies; imported by every module of the block.
package lgks_pkg;

    localparam int KEY_W      = 64;
    localparam int TICK_W     = 32;
    localparam int LIFESPAN_W = 49;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int HALF_W     = KEY_W / 2;

    localparam logic [FUNC_W-1:0] FUNC_ARM      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_VALIDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORCE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LIFESPAN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE  = 8'd1;

    localparam logic [LIFESPAN_W-1:0] LIFESPAN_RESET = 49'd168000000;
    localparam logic [TICK_W-1:0]     SILENCE_RESET  = 32'd2520000000;

    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94D049BB133111EB;

    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int FIN_SHIFT   = 31;
    localparam int FINAL_ROT   = 13;

endpackage

@@ sv/lgks_mul32.sv @@
// lgks_mul32: shared 32x32 unsigned multiplier with a registered 64-bit product.
// Depends on lgks_pkg.
module lgks_mul32 (
    input  logic                        clk,
    input  logic [lgks_pkg::HALF_W-1:0] a,
    input  logic [lgks_pkg::HALF_W-1:0] b,
    output logic [lgks_pkg::KEY_W-1:0]  p
);
    import lgks_pkg::*;

    logic [KEY_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule

@@ sv/lgks_hash.sv @@
// lgks_hash: sequencer for the 64-bit finalizer hash and rotate-by-13.
// Each 64x64 low-half multiply is three passes through lgks_mul32. Depends on lgks_pkg.
module lgks_hash (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lgks_pkg::KEY_W-1:0]  id,
    input  logic [lgks_pkg::TICK_W-1:0] tick,
    output logic                        done,
    output logic [lgks_pkg::KEY_W-1:0]  result
);
    import lgks_pkg::*;

    typedef enum logic [1:0] {H_IDLE, H_MIX, H_MUL, H_FIN} hstate_t;

    hstate_t          state_reg, state_next;
    logic             round_reg, round_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [KEY_W-1:0] z_reg, z_next;
    logic [KEY_W-1:0] x_reg, x_next;
    logic [KEY_W-1:0] acc_reg, acc_next;
    logic             done_reg, done_next;
    logic [KEY_W-1:0] result_reg, result_next;

    logic [KEY_W-1:0]  mul_c;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [KEY_W-1:0]  mul_p;
    logic [KEY_W-1:0]  acc_add;
    logic [KEY_W-1:0]  fin_w;

    lgks_mul32 u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign mul_c   = round_reg ? MIX_MUL_B : MIX_MUL_A;
    assign acc_add = {acc_reg[KEY_W-1:HALF_W] + mul_p[HALF_W-1:0], acc_reg[HALF_W-1:0]};
    assign fin_w   = z_reg ^ (z_reg >> FIN_SHIFT);

    // partial products: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_c[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = mul_c[KEY_W-1:HALF_W];
            end
            default:
            begin
                mul_a = x_reg[KEY_W-1:HALF_W];
                mul_b = mul_c[HALF_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        cnt_next    = cnt_reg;
        z_next      = z_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    z_next     = id + {{(KEY_W-TICK_W){1'b0}}, tick};
                    round_next = 1'b0;
                    state_next = H_MIX;
                end
            end
            H_MIX:
            begin
                x_next     = round_reg ? (z_reg ^ (z_reg >> MIX_SHIFT_B))
                                       : (z_reg ^ (z_reg >> MIX_SHIFT_A));
                cnt_next   = 2'd0;
                state_next = H_MUL;
            end
            H_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd0:
                    begin
                        acc_next = acc_reg;
                    end
                    2'd1:
                    begin
                        acc_next = mul_p;
                    end
                    2'd2:
                    begin
                        acc_next = acc_add;
                    end
                    default:
                    begin
                        z_next = acc_add;
                        if (round_reg)
                        begin
                            state_next = H_FIN;
                        end
                        else
                        begin
                            round_next = 1'b1;
                            state_next = H_MIX;
                        end
                    end
                endcase
            end
            H_FIN:
            begin
                result_next = (fin_w << FINAL_ROT) | (fin_w >> (KEY_W - FINAL_ROT));
                done_next   = 1'b1;
                state_next  = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= H_IDLE;
            done_reg   <= 1'b0;
            round_reg  <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            round_reg  <= round_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg      <= z_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/lifespan_guard_key_shredder_top.sv @@
// lifespan_guard_key_shredder_top: key-lifetime watchdog with a hash-based key shredder.
// Arm/force/unused: S_ADD, S_OUT, then the output register. Live validate: timing add (S_ADD),
// then compare (S_CMP). Collapsed validate: waits in S_HASH on six passes through the one shared
// 32x32 multiplier in lgks_hash. One word in flight; the next is taken once the result moves
// to the output register. Async active-low reset: block alive, timing zeroed, limits at reset.
// Depends on lgks_pkg, lgks_hash, lgks_mul32.
module lifespan_guard_key_shredder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lgks_pkg::FUNC_W-1:0]     func,
    input  logic [lgks_pkg::KEY_W-1:0]      sess_id,
    input  logic [lgks_pkg::TICK_W-1:0]     cur_tick,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lgks_pkg::KEY_W-1:0]      key_out,
    output logic                            collapsed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgks_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgks_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lgks_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_CMP, S_HASH, S_OUT} state_t;

    state_t                state_reg, state_next;
    logic                  dead_reg, dead_next;
    logic [TICK_W-1:0]     prev_tick_reg, prev_tick_next;
    logic [KEY_W-1:0]      total_reg, total_next;
    logic                  silent_reg, silent_next;
    logic [LIFESPAN_W-1:0] lifespan_reg, lifespan_next;
    logic [TICK_W-1:0]     silence_reg, silence_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [KEY_W-1:0]      sid_reg, sid_next;
    logic [TICK_W-1:0]     now_reg, now_next;
    logic [KEY_W-1:0]      res_key_reg, res_key_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]      key_out_reg, key_out_next;
    logic                  collapsed_reg, collapsed_next;

    logic              hash_start;
    logic              hash_done;
    logic [KEY_W-1:0]  hash_key;
    logic [TICK_W-1:0] delta;
    logic [KEY_W:0]    sum;

    lgks_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .id     (sid_reg),
        .tick   (now_reg),
        .done   (hash_done),
        .result (hash_key)
    );

    assign delta = now_reg - prev_tick_reg;
    assign sum   = {1'b0, total_reg} + {{(KEY_W-TICK_W+1){1'b0}}, delta};

    always_comb
    begin
        state_next     = state_reg;
        dead_next      = dead_reg;
        prev_tick_next = prev_tick_reg;
        total_next     = total_reg;
        silent_next    = silent_reg;
        lifespan_next  = lifespan_reg;
        silence_next   = silence_reg;
        func_next      = func_reg;
        sid_next       = sid_reg;
        now_next       = now_reg;
        res_key_next   = res_key_reg;
        out_valid_next = out_valid_reg;
        key_out_next   = key_out_reg;
        collapsed_next = collapsed_reg;
        hash_start     = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIFESPAN: lifespan_next = cfg_data[LIFESPAN_W-1:0];
                REG_SILENCE:  silence_next  = cfg_data[TICK_W-1:0];
                default:      ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    sid_next   = sess_id;
                    now_next   = cur_tick;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                res_key_next = '0;
                state_next   = S_OUT;
                case (func_reg)
                    FUNC_ARM:
                    begin
                        prev_tick_next = now_reg;
                        total_next     = '0;
                    end
                    FUNC_FORCE:
                    begin
                        dead_next = 1'b1;
                    end
                    FUNC_VALIDATE:
                    begin
                        if (dead_reg)
                        begin
                            hash_start = 1'b1;
                            state_next = S_HASH;
                        end
                        else
                        begin
                            prev_tick_next = now_reg;
                            total_next     = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
                            silent_next    = delta > silence_reg;
                            state_next     = S_CMP;
                        end
                    end
                    default: ;
                endcase
            end
            S_CMP:
            begin
                if (silent_reg || (total_reg > {{(KEY_W-LIFESPAN_W){1'b0}}, lifespan_reg}))
                begin
                    dead_next  = 1'b1;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
                else
                begin
                    res_key_next = sid_reg;
                    state_next   = S_OUT;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    res_key_next = hash_key;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    key_out_next   = res_key_reg;
                    collapsed_next = dead_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dead_reg      <= 1'b0;
            prev_tick_reg <= '0;
            total_reg     <= '0;
            silent_reg    <= 1'b0;
            lifespan_reg  <= LIFESPAN_RESET;
            silence_reg   <= SILENCE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dead_reg      <= dead_next;
            prev_tick_reg <= prev_tick_next;
            total_reg     <= total_next;
            silent_reg    <= silent_next;
            lifespan_reg  <= lifespan_next;
            silence_reg   <= silence_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        sid_reg       <= sid_next;
        now_reg       <= now_next;
        res_key_reg   <= res_key_next;
        key_out_reg   <= key_out_next;
        collapsed_reg <= collapsed_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign collapsed = collapsed_reg;

    // collapse is permanent until reset
    a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |=> dead_reg)
        else $error("collapse cleared without reset");

    // hash results only land while waiting for them
    a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash done outside hash wait");

    // a live block never shows a key other than the session id or zero
    a_live_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !dead_reg) |-> (res_key_reg == sid_reg || res_key_reg == '0))
        else $error("live block produced a hashed key");

    // one word at a time
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while busy");

endmodule
